// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the project (ssu_checker.sv).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is active.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Concurrent assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== design/ssu_pkg.sv =====
// ----------------------------------------------------------------------------
// ssu_pkg
// Op codes, decode types and the op decoder of the 128-bit shift unit.
// ----------------------------------------------------------------------------
package ssu_pkg;

  // Op codes in instruction-table order
  typedef enum logic [4:0] {
    OP_DSRA   = 5'd0,
    OP_DSLL   = 5'd1,
    OP_DSLL32 = 5'd2,
    OP_DSLLV  = 5'd3,
    OP_DSRA32 = 5'd4,
    OP_DSRAV  = 5'd5,
    OP_DSRL   = 5'd6,
    OP_DSRL32 = 5'd7,
    OP_DSRLV  = 5'd8,
    OP_SLL    = 5'd9,
    OP_SLLV   = 5'd10,
    OP_SRA    = 5'd11,
    OP_SRAV   = 5'd12,
    OP_SRL    = 5'd13,
    OP_SRLV   = 5'd14,
    OP_PSLLH  = 5'd15,
    OP_PSLLVW = 5'd16,
    OP_PSLLW  = 5'd17,
    OP_PSRAH  = 5'd18,
    OP_PSRAVW = 5'd19,
    OP_PSRAW  = 5'd20,
    OP_PSRLH  = 5'd21,
    OP_PSRLVW = 5'd22,
    OP_PSRLW  = 5'd23,
    OP_QFSRV  = 5'd24
  } op_e;

  // Shift direction / fill
  typedef enum logic [1:0] {
    SH_LEFT,
    SH_LOGIC,
    SH_ARITH
  } shift_kind_e;

  // Element layout of the shifted operand
  typedef enum logic [2:0] {
    ELEM_NONE,
    ELEM_DWORD,
    ELEM_WORD,
    ELEM_HALF_PK,
    ELEM_WORD_PK,
    ELEM_FUNNEL
  } elem_e;

  // Where the shift amount comes from
  typedef enum logic [1:0] {
    AMT_IMM,
    AMT_IMM32,
    AMT_REG
  } amt_src_e;

  typedef struct packed {
    elem_e       elem;
    shift_kind_e kind;
    amt_src_e    amt_src;
    logic        upper;
  } dec_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic        upper;
  } res_t;

  function automatic dec_t mk_dec(elem_e elem, shift_kind_e kind, amt_src_e src,
                                  logic upper);
    dec_t d;
    d.elem    = elem;
    d.kind    = kind;
    d.amt_src = src;
    d.upper   = upper;
    return d;
  endfunction

  function automatic dec_t decode_op(logic [4:0] op);
    dec_t d;
    d = mk_dec(ELEM_NONE, SH_LEFT, AMT_IMM, 1'b0);
    case (op_e'(op))
      OP_DSRA:   d = mk_dec(ELEM_DWORD,   SH_ARITH, AMT_IMM,   1'b0);
      OP_DSLL:   d = mk_dec(ELEM_DWORD,   SH_LEFT,  AMT_IMM,   1'b0);
      OP_DSLL32: d = mk_dec(ELEM_DWORD,   SH_LEFT,  AMT_IMM32, 1'b0);
      OP_DSLLV:  d = mk_dec(ELEM_DWORD,   SH_LEFT,  AMT_REG,   1'b0);
      OP_DSRA32: d = mk_dec(ELEM_DWORD,   SH_ARITH, AMT_IMM32, 1'b0);
      OP_DSRAV:  d = mk_dec(ELEM_DWORD,   SH_ARITH, AMT_REG,   1'b0);
      OP_DSRL:   d = mk_dec(ELEM_DWORD,   SH_LOGIC, AMT_IMM,   1'b0);
      OP_DSRL32: d = mk_dec(ELEM_DWORD,   SH_LOGIC, AMT_IMM32, 1'b0);
      OP_DSRLV:  d = mk_dec(ELEM_DWORD,   SH_LOGIC, AMT_REG,   1'b0);
      OP_SLL:    d = mk_dec(ELEM_WORD,    SH_LEFT,  AMT_IMM,   1'b0);
      OP_SLLV:   d = mk_dec(ELEM_WORD,    SH_LEFT,  AMT_REG,   1'b0);
      OP_SRA:    d = mk_dec(ELEM_WORD,    SH_ARITH, AMT_IMM,   1'b0);
      OP_SRAV:   d = mk_dec(ELEM_WORD,    SH_ARITH, AMT_REG,   1'b0);
      OP_SRL:    d = mk_dec(ELEM_WORD,    SH_LOGIC, AMT_IMM,   1'b0);
      OP_SRLV:   d = mk_dec(ELEM_WORD,    SH_LOGIC, AMT_REG,   1'b0);
      OP_PSLLH:  d = mk_dec(ELEM_HALF_PK, SH_LEFT,  AMT_IMM,   1'b1);
      OP_PSLLVW: d = mk_dec(ELEM_WORD,    SH_LEFT,  AMT_REG,   1'b1);
      OP_PSLLW:  d = mk_dec(ELEM_WORD_PK, SH_LEFT,  AMT_IMM,   1'b1);
      OP_PSRAH:  d = mk_dec(ELEM_HALF_PK, SH_ARITH, AMT_IMM,   1'b1);
      OP_PSRAVW: d = mk_dec(ELEM_WORD,    SH_ARITH, AMT_REG,   1'b1);
      OP_PSRAW:  d = mk_dec(ELEM_WORD_PK, SH_ARITH, AMT_IMM,   1'b1);
      OP_PSRLH:  d = mk_dec(ELEM_HALF_PK, SH_LOGIC, AMT_IMM,   1'b1);
      OP_PSRLVW: d = mk_dec(ELEM_WORD,    SH_LOGIC, AMT_REG,   1'b1);
      OP_PSRLW:  d = mk_dec(ELEM_WORD_PK, SH_LOGIC, AMT_IMM,   1'b1);
      OP_QFSRV:  d = mk_dec(ELEM_FUNNEL,  SH_LOGIC, AMT_IMM,   1'b1);
      default:   d = mk_dec(ELEM_NONE,    SH_LEFT,  AMT_IMM,   1'b0);
    endcase
    return d;
  endfunction

endpackage

// ===== design/ssu_lane.sv =====
// ----------------------------------------------------------------------------
// ssu_lane
// One 64-bit shift lane: doubleword, sign-extended word, packed halfword
// and packed word shifts of one doubleword of the operand.
// ----------------------------------------------------------------------------
module ssu_lane (
  input  ssu_pkg::dec_t dec_i,
  input  logic [63:0]   data_i,
  input  logic [63:0]   rs_i,
  input  logic [4:0]    imm_i,
  output logic [63:0]   res_o
);
  import ssu_pkg::*;

  logic [5:0]  amt;
  logic [63:0] dw_res;
  logic [31:0] w_res;
  logic [63:0] half_res;
  logic [63:0] wpk_res;

  // Shift amount: immediate, immediate + 32, or low bits of rs
  always_comb begin
    case (dec_i.amt_src)
      AMT_IMM:   amt = {1'b0, imm_i};
      AMT_IMM32: amt = {1'b1, imm_i};
      AMT_REG:   amt = rs_i[5:0];
      default:   amt = '0;
    endcase
  end

  // Full doubleword shift
  always_comb begin
    case (dec_i.kind)
      SH_LEFT:  dw_res = data_i << amt;
      SH_LOGIC: dw_res = data_i >> amt;
      SH_ARITH: dw_res = $unsigned($signed(data_i) >>> amt);
      default:  dw_res = '0;
    endcase
  end

  // Low word shift, sign-extended afterwards
  always_comb begin
    case (dec_i.kind)
      SH_LEFT:  w_res = data_i[31:0] << amt[4:0];
      SH_LOGIC: w_res = data_i[31:0] >> amt[4:0];
      SH_ARITH: w_res = $unsigned($signed(data_i[31:0]) >>> amt[4:0]);
      default:  w_res = '0;
    endcase
  end

  // Four packed halfwords, amount masked to 4 bits
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      case (dec_i.kind)
        SH_LEFT:  half_res[16*i +: 16] = data_i[16*i +: 16] << amt[3:0];
        SH_LOGIC: half_res[16*i +: 16] = data_i[16*i +: 16] >> amt[3:0];
        SH_ARITH: half_res[16*i +: 16] =
                    $unsigned($signed(data_i[16*i +: 16]) >>> amt[3:0]);
        default:  half_res[16*i +: 16] = '0;
      endcase
    end
  end

  // Two packed words, no sign extension between them
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      case (dec_i.kind)
        SH_LEFT:  wpk_res[32*i +: 32] = data_i[32*i +: 32] << amt[4:0];
        SH_LOGIC: wpk_res[32*i +: 32] = data_i[32*i +: 32] >> amt[4:0];
        SH_ARITH: wpk_res[32*i +: 32] =
                    $unsigned($signed(data_i[32*i +: 32]) >>> amt[4:0]);
        default:  wpk_res[32*i +: 32] = '0;
      endcase
    end
  end

  // Pick the form the op asks for
  always_comb begin
    case (dec_i.elem)
      ELEM_DWORD:   res_o = dw_res;
      ELEM_WORD:    res_o = {{32{w_res[31]}}, w_res};
      ELEM_HALF_PK: res_o = half_res;
      ELEM_WORD_PK: res_o = wpk_res;
      default:      res_o = '0;
    endcase
  end

endmodule

// ===== design/ssu_merge.sv =====
// ----------------------------------------------------------------------------
// ssu_merge
// Combines the two lane results with the 128-bit funnel shift and sets the
// upper-doubleword write flag.
// ----------------------------------------------------------------------------
module ssu_merge (
  input  ssu_pkg::dec_t dec_i,
  input  logic [63:0]   lane_lo_i,
  input  logic [63:0]   lane_hi_i,
  input  logic [63:0]   rt_low_i,
  input  logic [63:0]   rt_high_i,
  input  logic [63:0]   rs_low_i,
  input  logic [63:0]   rs_high_i,
  input  logic [7:0]    funnel_amount_i,
  output ssu_pkg::res_t res_o
);
  import ssu_pkg::*;

  logic [255:0] funnel_cat;
  logic [255:0] funnel_sh;

  // rs on top, rt at the bottom; zeros come in from above rs
  assign funnel_cat = {rs_high_i, rs_low_i, rt_high_i, rt_low_i};
  assign funnel_sh  = funnel_cat >> funnel_amount_i;

  always_comb begin
    res_o.upper = dec_i.upper;
    if (dec_i.elem == ELEM_FUNNEL) begin
      res_o.lo = funnel_sh[63:0];
      res_o.hi = funnel_sh[127:64];
    end else begin
      res_o.lo = lane_lo_i;
      // scalar ops leave the upper half at zero
      res_o.hi = dec_i.upper ? lane_hi_i : '0;
    end
  end

endmodule

// ===== design/simd_shift_unit_128.sv =====
// ----------------------------------------------------------------------------
// simd_shift_unit_128
// Shift execution unit of a 128-bit core: scalar 64/32-bit shifts, packed
// halfword/word shifts and the 128-bit funnel shift.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one item (op, rt, rs,
//   immediate amount, funnel amount). An item is taken when in_valid_i is
//   high and in_stall_o is low.
//   Output channel: out_valid_o / out_stall_i carry one result item
//   (128-bit result and the upper-written flag) per input item, in order.
//   The result is registered. Throughput: one item per cycle while
//   in_stall_o is low; all shifting is done by two 64-bit lanes and the
//   funnel shifter in the cycle of acceptance.
//   When the receiver stalls, the result holds and one more item is caught
//   in a skid register; in_stall_o rises only once that register is full.
//   Reset empties the output and skid registers; no item is pending after.
// ----------------------------------------------------------------------------
module simd_shift_unit_128 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  op_i,
  input  logic [63:0] rt_low_i,
  input  logic [63:0] rt_high_i,
  input  logic [63:0] rs_low_i,
  input  logic [63:0] rs_high_i,
  input  logic [4:0]  imm_amount_i,
  input  logic [7:0]  funnel_amount_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_low_o,
  output logic [63:0] result_high_o,
  output logic        upper_written_o
);
  import ssu_pkg::*;

  dec_t        dec;
  logic [63:0] lane_lo;
  logic [63:0] lane_hi;
  res_t        merged;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q;
  logic out_take, in_acc;
  logic out_load, out_from_skid, skid_load;

  assign dec = decode_op(op_i);

  // Lane for the low doubleword
  ssu_lane u_lane_lo (
    .dec_i  (dec),
    .data_i (rt_low_i),
    .rs_i   (rs_low_i),
    .imm_i  (imm_amount_i),
    .res_o  (lane_lo)
  );

  // Lane for the high doubleword
  ssu_lane u_lane_hi (
    .dec_i  (dec),
    .data_i (rt_high_i),
    .rs_i   (rs_high_i),
    .imm_i  (imm_amount_i),
    .res_o  (lane_hi)
  );

  ssu_merge u_merge (
    .dec_i           (dec),
    .lane_lo_i       (lane_lo),
    .lane_hi_i       (lane_hi),
    .rt_low_i        (rt_low_i),
    .rt_high_i       (rt_high_i),
    .rs_low_i        (rs_low_i),
    .rs_high_i       (rs_high_i),
    .funnel_amount_i (funnel_amount_i),
    .res_o           (merged)
  );

  // Output register plus skid register
  assign out_take = out_valid_q & ~out_stall_i;
  assign in_acc   = in_valid_i & ~skid_valid_q;

  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    out_load      = 1'b0;
    out_from_skid = 1'b0;
    skid_load     = 1'b0;
    if (skid_valid_q) begin
      if (out_take) begin
        out_load      = 1'b1;
        out_from_skid = 1'b1;
        skid_valid_d  = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_q || out_take) begin
        out_load    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        skid_load    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_d = out_from_skid ? skid_q : merged;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
    if (skid_load) begin
      skid_q <= merged;
    end
  end

  assign in_stall_o      = skid_valid_q;
  assign out_valid_o     = out_valid_q;
  assign result_low_o    = out_q.lo;
  assign result_high_o   = out_q.hi;
  assign upper_written_o = out_q.upper;

endmodule

// ===== design/ssu_checker.sv =====
// ----------------------------------------------------------------------------
// ssu_checker
// Port-level checks of the shift unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] result_low_o,
  input logic [63:0] result_high_o,
  input logic        upper_written_o
);

  logic         out_held;
  logic         scalar_out;
  logic [128:0] out_payload;

  assign out_held    = out_valid_o && out_stall_i;
  assign scalar_out  = out_valid_o && !upper_written_o;
  assign out_payload = {result_high_o, result_low_o, upper_written_o};

  // nothing is pending right after reset
  `ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |=> !out_valid_o)

  // input stalls only while a result is held at the output
  `ASSERT_RST(a_stall_has_out, clk_i, rst_ni, in_stall_o |-> out_valid_o)

  // an accepted item is always followed by a valid output in the next cycle
  `ASSERT_RST(a_acc_to_out, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> out_valid_o)

  // held result does not change while stalled
  `ASSERT_RST(a_hold, clk_i, rst_ni, out_held |=> (out_valid_o && $stable(out_payload)))

  // scalar results leave the upper doubleword at zero
  `ASSERT_RST(a_scalar_hi, clk_i, rst_ni, scalar_out |-> (result_high_o == 64'd0))

endmodule

bind simd_shift_unit_128 ssu_checker u_ssu_checker (.*);
